### design/ddts_pkg.sv
// ----------------------------------------------------------------------------
// ddts_pkg: types and constants for the disk drive tag sequencer
// command and result word layouts, register indexes, reset values, codes
// ----------------------------------------------------------------------------
package ddts_pkg;

  // bus and job id sizes
  localparam int BUS_WIDTH   = 10;
  localparam int JOB_ID_BITS = 16;

  // field widths
  localparam int CMD_BITS     = 3;
  localparam int CYL_BITS     = 10;
  localparam int HEAD_BITS    = 3;
  localparam int ERR_BITS     = 2;
  localparam int ELAPSED_BITS = 20;
  localparam int CFG_IDX_BITS = 3;
  localparam int CFG_DATA_BITS = 20;

  // control bit placed on the bus by the return to zero strobe
  localparam int RTZ_BIT_POS = 6;

  // command codes
  localparam logic [CMD_BITS-1:0] CMD_TICK   = 3'd0;
  localparam logic [CMD_BITS-1:0] CMD_UNIT   = 3'd1;
  localparam logic [CMD_BITS-1:0] CMD_CYL    = 3'd2;
  localparam logic [CMD_BITS-1:0] CMD_HEAD   = 3'd3;
  localparam logic [CMD_BITS-1:0] CMD_RTZ    = 3'd4;
  localparam logic [CMD_BITS-1:0] CMD_CANCEL = 3'd5;

  // error codes
  localparam logic [ERR_BITS-1:0] ERR_NONE    = 2'd0;
  localparam logic [ERR_BITS-1:0] ERR_DRIVE   = 2'd1;
  localparam logic [ERR_BITS-1:0] ERR_TIMEOUT = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_STROBE_TICKS   = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_RTZ_HOLD_TICKS = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_HEAD_SETTLE    = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_UNIT_TIMEOUT   = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_ONCYL_TIMEOUT  = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_SEEK_TIMEOUT   = 3'd5;

  // register reset values
  localparam logic [7:0]              RST_STROBE_TICKS   = 8'd2;
  localparam logic [15:0]             RST_RTZ_HOLD_TICKS = 16'd1000;
  localparam logic [15:0]             RST_HEAD_SETTLE    = 16'd40;
  localparam logic [ELAPSED_BITS-1:0] RST_UNIT_TIMEOUT   = 20'd100000;
  localparam logic [ELAPSED_BITS-1:0] RST_ONCYL_TIMEOUT  = 20'd50000;
  localparam logic [ELAPSED_BITS-1:0] RST_SEEK_TIMEOUT   = 20'd1000000;

  typedef struct packed {
    logic [CMD_BITS-1:0]  command;
    logic [CYL_BITS-1:0]  cylinder_number;
    logic [HEAD_BITS-1:0] head_number;
    logic                 fault_pin;
    logic                 seek_error_pin;
    logic                 unit_selected_pin;
    logic                 on_cylinder_pin;
    logic                 seek_end_pin;
  } cmd_word_t;

  typedef struct packed {
    logic [BUS_WIDTH-1:0]   bus_bits;
    logic                   unit_select_tag;
    logic                   tag_one;
    logic                   tag_two;
    logic                   tag_three;
    logic                   busy_res;
    logic [JOB_ID_BITS-1:0] job_number;
    logic [JOB_ID_BITS-1:0] completed_job;
    logic [JOB_ID_BITS-1:0] failed_job;
    logic [ERR_BITS-1:0]    error_status;
  } res_word_t;

endpackage

### design/disk_drive_tag_sequencer.sv
// ----------------------------------------------------------------------------
// disk_drive_tag_sequencer: tag and bus line sequencer for a disk drive
// runs select unit, cylinder, head and return to zero jobs on a 1 us tick
// ----------------------------------------------------------------------------
//
// channel | direction | handshake              | word
// --------+-----------+------------------------+--------------------------
// cmd     | in        | cmd_valid / cmd_stall  | cmd_word (tick or command)
// res     | out       | res_valid / res_stall  | res_word (lines and ids)
// cfg     | in        | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// the sequencer state steps at the edge a cmd word is accepted and the
// matching result word sits in the output register the next cycle. a new cmd
// word is taken every cycle unless the output register holds a word that is
// stalled. reset (rst, synchronous) clears the state, job ids and error, and
// loads the register defaults. cfg_ready is always high.
//
module disk_drive_tag_sequencer (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cmd_valid,
  output logic                                 cmd_stall,
  input  ddts_pkg::cmd_word_t                  cmd_word,
  output logic                                 res_valid,
  input  logic                                 res_stall,
  output ddts_pkg::res_word_t                  res_word,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [ddts_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [ddts_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

  localparam int EW = ddts_pkg::ELAPSED_BITS;
  localparam int JW = ddts_pkg::JOB_ID_BITS;

  // sequencer phases
  localparam logic [2:0] PH_IDLE         = 3'd0;
  localparam logic [2:0] PH_STROBE       = 3'd1;
  localparam logic [2:0] PH_WAIT_UNIT    = 3'd2;
  localparam logic [2:0] PH_WAIT_OFFCYL  = 3'd3;
  localparam logic [2:0] PH_WAIT_SEEK    = 3'd4;
  localparam logic [2:0] PH_SETTLE       = 3'd5;
  localparam logic [2:0] PH_RTZ_HOLD     = 3'd6;
  localparam logic [2:0] PH_CLEAR_STROBE = 3'd7;

  localparam logic [EW-1:0] ELAPSED_MAX = {EW{1'b1}};

  // configuration registers
  logic [7:0]    strobe_ticks;
  logic [15:0]   rtz_hold_ticks;
  logic [15:0]   head_settle_ticks;
  logic [EW-1:0] unit_timeout;
  logic [EW-1:0] oncyl_drop_timeout;
  logic [EW-1:0] seek_timeout;

  // sequencer state
  logic [2:0]                        phase, phase_next;
  logic [ddts_pkg::CMD_BITS-1:0]     job_kind, job_kind_next;
  logic [EW-1:0]                     elapsed, elapsed_next;
  logic [ddts_pkg::CYL_BITS-1:0]     latched_cylinder, latched_cylinder_next;
  logic [ddts_pkg::HEAD_BITS-1:0]    latched_head, latched_head_next;
  logic [JW-1:0]                     job_counter, job_counter_next;
  logic [JW-1:0]                     done_id, done_id_next;
  logic [JW-1:0]                     fail_id, fail_id_next;
  logic [ddts_pkg::ERR_BITS-1:0]     last_error, last_error_next;

  logic                accept;
  logic                is_cmd;
  logic                drive_err;
  logic [EW-1:0]       elapsed_inc;
  logic [EW-1:0]       count_limit;
  logic                count_done;
  ddts_pkg::res_word_t result;

  // output register frees up when it is empty or being taken
  assign cmd_stall = res_valid & res_stall;
  assign accept    = cmd_valid & ~cmd_stall;
  assign cfg_ready = 1'b1;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe_ticks       <= ddts_pkg::RST_STROBE_TICKS;
      rtz_hold_ticks     <= ddts_pkg::RST_RTZ_HOLD_TICKS;
      head_settle_ticks  <= ddts_pkg::RST_HEAD_SETTLE;
      unit_timeout       <= ddts_pkg::RST_UNIT_TIMEOUT;
      oncyl_drop_timeout <= ddts_pkg::RST_ONCYL_TIMEOUT;
      seek_timeout       <= ddts_pkg::RST_SEEK_TIMEOUT;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ddts_pkg::REG_STROBE_TICKS:   strobe_ticks       <= cfg_data[7:0];
        ddts_pkg::REG_RTZ_HOLD_TICKS: rtz_hold_ticks     <= cfg_data[15:0];
        ddts_pkg::REG_HEAD_SETTLE:    head_settle_ticks  <= cfg_data[15:0];
        ddts_pkg::REG_UNIT_TIMEOUT:   unit_timeout       <= cfg_data[EW-1:0];
        ddts_pkg::REG_ONCYL_TIMEOUT:  oncyl_drop_timeout <= cfg_data[EW-1:0];
        ddts_pkg::REG_SEEK_TIMEOUT:   seek_timeout       <= cfg_data[EW-1:0];
        default: ;
      endcase
    end
  end

  assign is_cmd = (cmd_word.command inside {[ddts_pkg::CMD_UNIT:ddts_pkg::CMD_CANCEL]});
  assign drive_err = cmd_word.fault_pin | cmd_word.seek_error_pin;

  // saturating count for fixed waits
  assign elapsed_inc = (elapsed == ELAPSED_MAX) ? elapsed : elapsed + 1'b1;

  // limit of the fixed wait in the current phase
  always_comb begin
    case (phase)
      PH_SETTLE:   count_limit = EW'(head_settle_ticks);
      PH_RTZ_HOLD: count_limit = EW'(rtz_hold_ticks);
      default:     count_limit = EW'(strobe_ticks);
    endcase
  end
  assign count_done = (elapsed_inc >= count_limit);

  // one sequencer step per accepted word
  always_comb begin
    phase_next            = phase;
    job_kind_next         = job_kind;
    elapsed_next          = elapsed;
    latched_cylinder_next = latched_cylinder;
    latched_head_next     = latched_head;
    job_counter_next      = job_counter;
    done_id_next          = done_id;
    fail_id_next          = fail_id;
    last_error_next       = last_error;

    if (is_cmd) begin
      // any command aborts the running job and starts a new one
      job_counter_next = job_counter + 1'b1;
      job_kind_next    = cmd_word.command;
      if (cmd_word.command == ddts_pkg::CMD_CYL) begin
        latched_cylinder_next = cmd_word.cylinder_number;
      end
      if (cmd_word.command == ddts_pkg::CMD_HEAD) begin
        latched_head_next = cmd_word.head_number;
      end
      phase_next   = PH_STROBE;
      elapsed_next = '0;
    end else begin
      case (phase)
        PH_STROBE: begin
          elapsed_next = elapsed_inc;
          if (count_done) begin
            elapsed_next = '0;
            case (job_kind)
              ddts_pkg::CMD_UNIT: phase_next = PH_WAIT_UNIT;
              ddts_pkg::CMD_CYL:  phase_next = PH_WAIT_OFFCYL;
              ddts_pkg::CMD_HEAD: phase_next = PH_SETTLE;
              default:            phase_next = PH_RTZ_HOLD;
            endcase
          end
        end
        PH_WAIT_UNIT, PH_WAIT_OFFCYL, PH_WAIT_SEEK: begin
          // match first, then drive error, then timeout
          if ((phase == PH_WAIT_UNIT && cmd_word.unit_selected_pin) ||
              (phase == PH_WAIT_OFFCYL && !cmd_word.on_cylinder_pin) ||
              (phase == PH_WAIT_SEEK && cmd_word.on_cylinder_pin &&
               cmd_word.seek_end_pin)) begin
            if (phase == PH_WAIT_OFFCYL) begin
              phase_next   = PH_WAIT_SEEK;
              elapsed_next = '0;
            end else begin
              done_id_next = job_counter;
              phase_next   = PH_IDLE;
            end
          end else if (drive_err) begin
            fail_id_next    = job_counter;
            last_error_next = ddts_pkg::ERR_DRIVE;
            phase_next      = PH_IDLE;
          end else if ((phase == PH_WAIT_UNIT && elapsed >= unit_timeout) ||
                       (phase == PH_WAIT_OFFCYL && elapsed >= oncyl_drop_timeout) ||
                       (phase == PH_WAIT_SEEK && elapsed >= seek_timeout)) begin
            fail_id_next    = job_counter;
            last_error_next = ddts_pkg::ERR_TIMEOUT;
            phase_next      = PH_IDLE;
          end else begin
            elapsed_next = elapsed + 1'b1;
          end
        end
        PH_SETTLE, PH_CLEAR_STROBE: begin
          elapsed_next = elapsed_inc;
          if (count_done) begin
            done_id_next = job_counter;
            phase_next   = PH_IDLE;
          end
        end
        PH_RTZ_HOLD: begin
          elapsed_next = elapsed_inc;
          if (count_done) begin
            // control clear strobe with an empty bus
            phase_next   = PH_CLEAR_STROBE;
            elapsed_next = '0;
          end
        end
        default: phase_next = PH_IDLE;
      endcase
    end
  end

  // lines and status after the step
  always_comb begin
    result                 = '0;
    result.busy_res        = (phase_next != PH_IDLE);
    result.job_number      = job_counter_next;
    result.completed_job   = done_id_next;
    result.failed_job      = fail_id_next;
    result.error_status    = last_error_next;
    if (phase_next == PH_STROBE) begin
      case (job_kind_next)
        ddts_pkg::CMD_UNIT: result.unit_select_tag = 1'b1;
        ddts_pkg::CMD_CYL: begin
          result.tag_one  = 1'b1;
          result.bus_bits = ddts_pkg::BUS_WIDTH'(latched_cylinder_next);
        end
        ddts_pkg::CMD_HEAD: begin
          result.tag_two  = 1'b1;
          result.bus_bits = ddts_pkg::BUS_WIDTH'(latched_head_next);
        end
        default: begin
          result.tag_three = 1'b1;
          result.bus_bits  = ddts_pkg::BUS_WIDTH'(1) << ddts_pkg::RTZ_BIT_POS;
        end
      endcase
    end else if (phase_next == PH_CLEAR_STROBE) begin
      result.tag_three = 1'b1;
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_IDLE;
      job_kind         <= '0;
      elapsed          <= '0;
      latched_cylinder <= '0;
      latched_head     <= '0;
      job_counter      <= '0;
      done_id          <= '0;
      fail_id          <= '0;
      last_error       <= ddts_pkg::ERR_NONE;
    end else if (accept) begin
      phase            <= phase_next;
      job_kind         <= job_kind_next;
      elapsed          <= elapsed_next;
      latched_cylinder <= latched_cylinder_next;
      latched_head     <= latched_head_next;
      job_counter      <= job_counter_next;
      done_id          <= done_id_next;
      fail_id          <= fail_id_next;
      last_error       <= last_error_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (accept) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_word <= result;
    end
  end

  // at most one tag line at a time
  assert property (@(posedge clk) disable iff (rst)
    res_valid |-> $onehot0({res_word.unit_select_tag, res_word.tag_one,
                            res_word.tag_two, res_word.tag_three}))
    else $error("more than one tag line high");

  // tags only while a job runs
  assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_word.busy_res) |->
      (!res_word.unit_select_tag && !res_word.tag_one && !res_word.tag_two &&
       !res_word.tag_three && res_word.bus_bits == '0))
    else $error("tag or bus driven while idle");

  // a command starts a strobe under a new job id
  assert property (@(posedge clk) disable iff (rst)
    (accept && is_cmd) |=>
      (res_valid && res_word.busy_res && res_word.job_number == $past(job_counter) + 1'b1))
    else $error("command did not start a new job");

  // a stalled output word is not replaced
  assert property (@(posedge clk) disable iff (rst)
    cmd_stall |-> !accept)
    else $error("word accepted while output register is stalled");

endmodule

### dv/disk_drive_tag_sequencer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// disk_drive_tag_sequencer_tb: self-checking bench for the tag sequencer
// sends tick and command words under random input idling and output stalls,
// predicts the bus, tag lines, job ids and error code of every result word
// and compares them field by field in arrival order
// ----------------------------------------------------------------------------
module disk_drive_tag_sequencer_tb;

  // spare command codes, the block treats them as ticks
  localparam logic [ddts_pkg::CMD_BITS-1:0] CMD_SPARE_SIX   = 3'd6;
  localparam logic [ddts_pkg::CMD_BITS-1:0] CMD_SPARE_SEVEN = 3'd7;

  // drive status pin masks: {fault, seek error, unit selected, on cyl, seek end}
  localparam logic [4:0] PINS_NONE    = 5'b00000;
  localparam logic [4:0] PIN_FAULT    = 5'b10000;
  localparam logic [4:0] PIN_SEEK_ERR = 5'b01000;
  localparam logic [4:0] PIN_UNIT_SEL = 5'b00100;
  localparam logic [4:0] PIN_ON_CYL   = 5'b00010;
  localparam logic [4:0] PIN_SEEK_END = 5'b00001;
  localparam logic [4:0] PINS_ALL     = 5'b11111;

  localparam logic [ddts_pkg::ELAPSED_BITS-1:0] COUNT_MAX = '1;
  localparam int CMD_WORD_BITS = $bits(ddts_pkg::cmd_word_t);

  typedef enum logic [3:0] {
    SEQ_IDLE, SEQ_STROBE, SEQ_WAIT_UNIT, SEQ_WAIT_OFFCYL, SEQ_WAIT_SEEK,
    SEQ_SETTLE, SEQ_RTZ_HOLD, SEQ_CLEAR_STROBE
  } seq_phase_e;

  logic                               clk;
  logic                               rst;
  logic                               cmd_valid;
  logic                               cmd_stall;
  ddts_pkg::cmd_word_t                cmd_word;
  logic                               res_valid;
  logic                               res_stall;
  ddts_pkg::res_word_t                res_word;
  logic                               cfg_valid;
  logic                               cfg_ready;
  logic [ddts_pkg::CFG_IDX_BITS-1:0]  cfg_index;
  logic [ddts_pkg::CFG_DATA_BITS-1:0] cfg_data;

  disk_drive_tag_sequencer dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd_word  (cmd_word),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_word  (res_word),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // sequencer registers as the bench sees them
  logic [7:0]                        strobe_len;
  logic [15:0]                       rtz_wait;
  logic [15:0]                       settle_wait;
  logic [ddts_pkg::ELAPSED_BITS-1:0] unit_limit;
  logic [ddts_pkg::ELAPSED_BITS-1:0] offcyl_limit;
  logic [ddts_pkg::ELAPSED_BITS-1:0] seek_limit;

  // sequencer state as the bench sees it
  seq_phase_e                        seq_phase;
  logic [ddts_pkg::CMD_BITS-1:0]     job_cmd;
  logic [ddts_pkg::ELAPSED_BITS-1:0] tick_count;
  logic [ddts_pkg::CYL_BITS-1:0]     cyl_latch;
  logic [ddts_pkg::HEAD_BITS-1:0]    head_latch;
  logic [ddts_pkg::JOB_ID_BITS-1:0]  job_id;
  logic [ddts_pkg::JOB_ID_BITS-1:0]  last_good_id;
  logic [ddts_pkg::JOB_ID_BITS-1:0]  last_bad_id;
  logic [ddts_pkg::ERR_BITS-1:0]     err_code;

  ddts_pkg::res_word_t due_res_words[$];
  int                  fail_count;
  int                  idle_pct;
  int                  stall_pct;

  function automatic void enter_phase(seq_phase_e p);
    seq_phase  = p;
    tick_count = '0;
  endfunction

  function automatic void job_ok();
    last_good_id = job_id;
    seq_phase    = SEQ_IDLE;
  endfunction

  function automatic void job_failed(logic [ddts_pkg::ERR_BITS-1:0] code);
    last_bad_id = job_id;
    err_code    = code;
    seq_phase   = SEQ_IDLE;
  endfunction

  // one tick of a fixed wait, true once the wait is over
  function automatic bit count_tick(logic [ddts_pkg::ELAPSED_BITS-1:0] limit);
    if (tick_count != COUNT_MAX) tick_count++;
    return tick_count >= limit;
  endfunction

  // one tick of a pin wait: match first, then drive error, then timeout
  function automatic bit watch_pins(bit match, bit drive_err,
                                    logic [ddts_pkg::ELAPSED_BITS-1:0] limit);
    if (match) return 1'b1;
    if (drive_err) job_failed(ddts_pkg::ERR_DRIVE);
    else if (tick_count >= limit) job_failed(ddts_pkg::ERR_TIMEOUT);
    else tick_count++;
    return 1'b0;
  endfunction

  // steps the bench state by one accepted word and returns the line word
  function automatic ddts_pkg::res_word_t predict_lines(ddts_pkg::cmd_word_t w);
    ddts_pkg::res_word_t r;
    bit                  drive_err;
    drive_err = w.fault_pin | w.seek_error_pin;
    if (w.command >= ddts_pkg::CMD_UNIT && w.command <= ddts_pkg::CMD_CANCEL) begin
      // any command aborts the running job
      job_id++;
      job_cmd = w.command;
      if (w.command == ddts_pkg::CMD_CYL) cyl_latch = w.cylinder_number;
      if (w.command == ddts_pkg::CMD_HEAD) head_latch = w.head_number;
      enter_phase(SEQ_STROBE);
    end else begin
      case (seq_phase)
        SEQ_STROBE: begin
          if (count_tick(ddts_pkg::ELAPSED_BITS'(strobe_len))) begin
            case (job_cmd)
              ddts_pkg::CMD_UNIT: enter_phase(SEQ_WAIT_UNIT);
              ddts_pkg::CMD_CYL:  enter_phase(SEQ_WAIT_OFFCYL);
              ddts_pkg::CMD_HEAD: enter_phase(SEQ_SETTLE);
              default:            enter_phase(SEQ_RTZ_HOLD);
            endcase
          end
        end
        SEQ_WAIT_UNIT: begin
          if (watch_pins(w.unit_selected_pin, drive_err, unit_limit)) job_ok();
        end
        SEQ_WAIT_OFFCYL: begin
          if (watch_pins(!w.on_cylinder_pin, drive_err, offcyl_limit))
            enter_phase(SEQ_WAIT_SEEK);
        end
        SEQ_WAIT_SEEK: begin
          if (watch_pins(w.on_cylinder_pin && w.seek_end_pin, drive_err, seek_limit))
            job_ok();
        end
        SEQ_SETTLE: begin
          if (count_tick(ddts_pkg::ELAPSED_BITS'(settle_wait))) job_ok();
        end
        SEQ_RTZ_HOLD: begin
          if (count_tick(ddts_pkg::ELAPSED_BITS'(rtz_wait))) enter_phase(SEQ_CLEAR_STROBE);
        end
        SEQ_CLEAR_STROBE: begin
          if (count_tick(ddts_pkg::ELAPSED_BITS'(strobe_len))) job_ok();
        end
        default: seq_phase = SEQ_IDLE;
      endcase
    end

    r = '0;
    if (seq_phase == SEQ_STROBE) begin
      case (job_cmd)
        ddts_pkg::CMD_UNIT: r.unit_select_tag = 1'b1;
        ddts_pkg::CMD_CYL: begin
          r.tag_one  = 1'b1;
          r.bus_bits = ddts_pkg::BUS_WIDTH'(cyl_latch);
        end
        ddts_pkg::CMD_HEAD: begin
          r.tag_two  = 1'b1;
          r.bus_bits = ddts_pkg::BUS_WIDTH'(head_latch);
        end
        default: begin
          r.tag_three = 1'b1;
          r.bus_bits  = ddts_pkg::BUS_WIDTH'(1) << ddts_pkg::RTZ_BIT_POS;
        end
      endcase
    end else if (seq_phase == SEQ_CLEAR_STROBE) begin
      r.tag_three = 1'b1;
    end
    r.busy_res      = (seq_phase != SEQ_IDLE);
    r.job_number    = job_id;
    r.completed_job = last_good_id;
    r.failed_job    = last_bad_id;
    r.error_status  = err_code;
    return r;
  endfunction

  function automatic ddts_pkg::cmd_word_t make_word(logic [ddts_pkg::CMD_BITS-1:0] c,
                                                    logic [ddts_pkg::CYL_BITS-1:0] cyl,
                                                    logic [ddts_pkg::HEAD_BITS-1:0] hd,
                                                    logic [4:0] pins);
    ddts_pkg::cmd_word_t w;
    w.command         = c;
    w.cylinder_number = cyl;
    w.head_number     = hd;
    {w.fault_pin, w.seek_error_pin, w.unit_selected_pin, w.on_cylinder_pin,
     w.seek_end_pin} = pins;
    return w;
  endfunction

  // one word through the cmd handshake, with random idle cycles ahead of it
  task automatic send_cmd(ddts_pkg::cmd_word_t w);
    while ($urandom_range(99) < idle_pct) begin
      cmd_valid <= 1'b0;
      @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd_word  <= w;
    do @(posedge clk); while (cmd_stall);
    due_res_words.push_back(predict_lines(w));
  endtask

  // ticks with fixed pins and random argument fields
  task automatic send_ticks(logic [4:0] pins, int count);
    for (int i = 0; i < count; i++) begin
      send_cmd(make_word(ddts_pkg::CMD_TICK, ddts_pkg::CYL_BITS'($urandom),
                         ddts_pkg::HEAD_BITS'($urandom), pins));
    end
  endtask

  // holds the sender until every pending result word has come back
  task automatic wait_all_results();
    cmd_valid <= 1'b0;
    do @(posedge clk); while (due_res_words.size() != 0);
  endtask

  task automatic write_reg(logic [ddts_pkg::CFG_IDX_BITS-1:0] idx,
                           logic [ddts_pkg::CFG_DATA_BITS-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      ddts_pkg::REG_STROBE_TICKS:   strobe_len   = data[7:0];
      ddts_pkg::REG_RTZ_HOLD_TICKS: rtz_wait     = data[15:0];
      ddts_pkg::REG_HEAD_SETTLE:    settle_wait  = data[15:0];
      ddts_pkg::REG_UNIT_TIMEOUT:   unit_limit   = data;
      ddts_pkg::REG_ONCYL_TIMEOUT:  offcyl_limit = data;
      ddts_pkg::REG_SEEK_TIMEOUT:   seek_limit   = data;
      default: ;
    endcase
  endtask

  // only called with the block drained
  task automatic write_all_regs(logic [19:0] s, logic [19:0] r, logic [19:0] h,
                                logic [19:0] u, logic [19:0] o, logic [19:0] k);
    write_reg(ddts_pkg::REG_STROBE_TICKS, s);
    write_reg(ddts_pkg::REG_RTZ_HOLD_TICKS, r);
    write_reg(ddts_pkg::REG_HEAD_SETTLE, h);
    write_reg(ddts_pkg::REG_UNIT_TIMEOUT, u);
    write_reg(ddts_pkg::REG_ONCYL_TIMEOUT, o);
    write_reg(ddts_pkg::REG_SEEK_TIMEOUT, k);
    cfg_valid <= 1'b0;
  endtask

  // reset values: a full head job, then a return to zero cut short by a unit select
  task automatic test_default_registers();
    idle_pct  = 0;
    stall_pct = 0;
    send_ticks(PINS_ALL, 2);
    send_cmd(make_word(ddts_pkg::CMD_HEAD, '1, 3'd7, PINS_NONE));
    send_ticks(PINS_NONE, 2 + 40 + 1);
    send_cmd(make_word(ddts_pkg::CMD_RTZ, '0, '0, PINS_NONE));
    send_ticks(PINS_NONE, 6);
    send_cmd(make_word(ddts_pkg::CMD_UNIT, '0, '0, PINS_NONE));
    send_ticks(PINS_NONE, 3);
    send_ticks(PIN_UNIT_SEL, 1);
    wait_all_results();
  endtask

  // every job ending: success, drive error, timeout, abort, spare codes
  task automatic test_directed_jobs();
    write_all_regs(20'd1, 20'd2, 20'd3, 20'd3, 20'd3, 20'd3);
    send_cmd(make_word(ddts_pkg::CMD_UNIT, '0, '0, PINS_NONE));
    send_ticks(PINS_NONE, 1);
    send_ticks(PIN_UNIT_SEL, 1);
    // a match wins over a fault on the same tick
    send_cmd(make_word(ddts_pkg::CMD_UNIT, '1, '1, PINS_ALL));
    send_ticks(PINS_NONE, 1);
    send_ticks(PIN_UNIT_SEL | PIN_FAULT, 1);
    send_cmd(make_word(ddts_pkg::CMD_UNIT, '0, '0, PINS_NONE));
    send_ticks(PINS_NONE, 1);
    send_ticks(PIN_SEEK_ERR, 1);
    // unit timeout
    send_cmd(make_word(ddts_pkg::CMD_UNIT, '0, '0, PINS_NONE));
    send_ticks(PINS_NONE, 5);
    // full seek: on cylinder drops, then on cylinder and seek end rise
    send_cmd(make_word(ddts_pkg::CMD_CYL, '1, '0, PIN_ON_CYL));
    send_ticks(PIN_ON_CYL, 2);
    send_ticks(PINS_NONE, 1);
    send_ticks(PIN_ON_CYL, 1);
    send_ticks(PIN_ON_CYL | PIN_SEEK_END, 1);
    // on cylinder never drops
    send_cmd(make_word(ddts_pkg::CMD_CYL, '0, '0, PINS_NONE));
    send_ticks(PIN_ON_CYL, 5);
    // fault during the seek wait
    send_cmd(make_word(ddts_pkg::CMD_CYL, 10'h2AA, '0, PINS_NONE));
    send_ticks(PINS_NONE, 2);
    send_ticks(PIN_FAULT, 1);
    // head settle aborted by cancel
    send_cmd(make_word(ddts_pkg::CMD_HEAD, 10'h155, 3'd7, PINS_NONE));
    send_ticks(PINS_NONE, 2);
    send_cmd(make_word(ddts_pkg::CMD_CANCEL, '0, '0, PINS_NONE));
    send_ticks(PINS_NONE, 5);
    // spare codes only count time
    send_cmd(make_word(ddts_pkg::CMD_RTZ, '0, 3'd2, PINS_NONE));
    send_cmd(make_word(CMD_SPARE_SIX, '1, '1, PINS_ALL));
    send_cmd(make_word(CMD_SPARE_SEVEN, '0, '0, PINS_ALL));
    send_ticks(PINS_NONE, 3);
    wait_all_results();
  endtask

  // all registers at zero, then all at their maximum
  task automatic test_register_extremes();
    write_all_regs('0, '0, '0, '0, '0, '0);
    // zero strobe length behaves as one tick
    send_cmd(make_word(ddts_pkg::CMD_HEAD, '0, 3'd5, PINS_NONE));
    send_ticks(PINS_NONE, 2);
    send_cmd(make_word(ddts_pkg::CMD_UNIT, '0, '0, PINS_NONE));
    send_ticks(PINS_NONE, 2);
    send_cmd(make_word(ddts_pkg::CMD_CYL, 10'h0F0, '0, PINS_NONE));
    send_ticks(PINS_NONE, 3);
    send_cmd(make_word(ddts_pkg::CMD_RTZ, '0, '0, PINS_NONE));
    send_ticks(PINS_NONE, 4);
    wait_all_results();
    write_all_regs(20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF);
    send_cmd(make_word(ddts_pkg::CMD_HEAD, '1, 3'd7, PINS_NONE));
    send_ticks(PINS_NONE, 8);
    send_cmd(make_word(ddts_pkg::CMD_UNIT, '0, '0, PINS_NONE));
    send_ticks(PIN_ON_CYL | PIN_SEEK_END, 6);
    send_ticks(PIN_UNIT_SEL, 1);
    send_cmd(make_word(ddts_pkg::CMD_RTZ, '0, '0, PINS_NONE));
    send_ticks(PINS_NONE, 6);
    send_cmd(make_word(ddts_pkg::CMD_CANCEL, '0, '0, PINS_NONE));
    send_ticks(PINS_NONE, 3);
    wait_all_results();
  endtask

  // random jobs with pin behavior picked per job, under four mixes of input idling and output stalls
  task automatic test_random_traffic();
    ddts_pkg::cmd_word_t w;
    int                  sent;
    int                  err_pct;
    int                  hi_pct;
    logic [19:0]         v_strobe;
    logic [19:0]         v_rtz;
    logic [19:0]         v_settle;
    for (int mix = 0; mix < 4; mix++) begin
      case (mix)
        0: begin
          idle_pct  = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct  = 68;
          stall_pct = 0;
        end
        2: begin
          idle_pct  = 0;
          stall_pct = 68;
        end
        default: begin
          idle_pct  = 14;
          stall_pct = 14;
        end
      endcase
      wait_all_results();
      v_strobe       = 20'($urandom);
      v_strobe[7:0]  = 8'($urandom_range(4));
      v_rtz          = 20'($urandom);
      v_rtz[15:0]    = 16'($urandom_range(6));
      v_settle       = 20'($urandom);
      v_settle[15:0] = 16'($urandom_range(8));
      write_all_regs(v_strobe, v_rtz, v_settle, 20'($urandom_range(12)),
                     20'($urandom_range(12)), 20'($urandom_range(12)));
      sent = 0;
      while (sent < 120) begin
        if ($urandom_range(99) < 8) begin
          // noise: any code, any pins
          repeat ($urandom_range(1, 4)) begin
            w = ddts_pkg::cmd_word_t'(CMD_WORD_BITS'($urandom));
            send_cmd(w);
            sent++;
          end
        end else begin
          case ($urandom_range(3))
            0: err_pct = 25;
            1: err_pct = 4;
            default: err_pct = 0;
          endcase
          case ($urandom_range(2))
            0: hi_pct = 15;
            1: hi_pct = 50;
            default: hi_pct = 85;
          endcase
          w = ddts_pkg::cmd_word_t'(CMD_WORD_BITS'($urandom));
          w.command = ddts_pkg::CMD_BITS'($urandom_range(ddts_pkg::CMD_CANCEL,
                                                         ddts_pkg::CMD_UNIT));
          send_cmd(w);
          sent++;
          // a short run of ticks, then the next command aborts the job if it still runs
          repeat ($urandom_range(20)) begin
            w = ddts_pkg::cmd_word_t'(CMD_WORD_BITS'($urandom));
            case ($urandom_range(15))
              0: w.command = CMD_SPARE_SIX;
              1: w.command = CMD_SPARE_SEVEN;
              default: w.command = ddts_pkg::CMD_TICK;
            endcase
            w.fault_pin         = ($urandom_range(99) < err_pct);
            w.seek_error_pin    = ($urandom_range(99) < err_pct);
            w.unit_selected_pin = ($urandom_range(99) < hi_pct);
            w.on_cylinder_pin   = ($urandom_range(99) < hi_pct);
            w.seek_end_pin      = ($urandom_range(99) < hi_pct);
            send_cmd(w);
            sent++;
          end
        end
        if ($urandom_range(29) == 0) wait_all_results();
      end
    end
  endtask

  // receiver stalls
  always @(posedge clk) res_stall <= ($urandom_range(99) < stall_pct);

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endfunction

  // result checker
  always @(posedge clk) begin
    ddts_pkg::res_word_t want;
    if (!rst && res_valid && !res_stall) begin
      if (due_res_words.size() == 0) begin
        $error("result word with no expected word pending");
        fail_count++;
      end else begin
        want = due_res_words.pop_front();
        check_field("bus_bits", 32'(want.bus_bits), 32'(res_word.bus_bits));
        check_field("unit_select_tag", 32'(want.unit_select_tag),
                    32'(res_word.unit_select_tag));
        check_field("tag_one", 32'(want.tag_one), 32'(res_word.tag_one));
        check_field("tag_two", 32'(want.tag_two), 32'(res_word.tag_two));
        check_field("tag_three", 32'(want.tag_three), 32'(res_word.tag_three));
        check_field("busy_res", 32'(want.busy_res), 32'(res_word.busy_res));
        check_field("job_number", 32'(want.job_number), 32'(res_word.job_number));
        check_field("completed_job", 32'(want.completed_job),
                    32'(res_word.completed_job));
        check_field("failed_job", 32'(want.failed_job), 32'(res_word.failed_job));
        check_field("error_status", 32'(want.error_status),
                    32'(res_word.error_status));
      end
    end
  end

  initial begin
    rst          = 1'b1;
    cmd_valid    = 1'b0;
    cmd_word     = '0;
    cfg_valid    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    idle_pct     = 0;
    stall_pct    = 0;
    fail_count   = 0;
    strobe_len   = ddts_pkg::RST_STROBE_TICKS;
    rtz_wait     = ddts_pkg::RST_RTZ_HOLD_TICKS;
    settle_wait  = ddts_pkg::RST_HEAD_SETTLE;
    unit_limit   = ddts_pkg::RST_UNIT_TIMEOUT;
    offcyl_limit = ddts_pkg::RST_ONCYL_TIMEOUT;
    seek_limit   = ddts_pkg::RST_SEEK_TIMEOUT;
    seq_phase    = SEQ_IDLE;
    job_cmd      = ddts_pkg::CMD_TICK;
    tick_count   = '0;
    cyl_latch    = '0;
    head_latch   = '0;
    job_id       = '0;
    last_good_id = '0;
    last_bad_id  = '0;
    err_code     = ddts_pkg::ERR_NONE;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_default_registers();
    test_directed_jobs();
    test_register_extremes();
    test_random_traffic();

    wait_all_results();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // watchdog, far beyond the slowest correct run
  initial begin
    #20_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

### files.f
design/ddts_pkg.sv
design/disk_drive_tag_sequencer.sv
dv/disk_drive_tag_sequencer_tb.sv
